>>> rtl/irfd_pkg.sv
package irfd_pkg;

  // field widths
  localparam int DUR_W     = 20;
  localparam int FRAME_BITS = 32;
  localparam int CNT_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  // item kinds
  localparam logic [1:0] REQ_RISE    = 2'd0;
  localparam logic [1:0] REQ_FALL    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_DATA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_REPEAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd5;

  // register reset values
  localparam logic [DUR_W-1:0] RST_HDR_MARK   = 20'd2812;
  localparam logic [DUR_W-1:0] RST_HDR_DATA   = 20'd1406;
  localparam logic [DUR_W-1:0] RST_HDR_REPEAT = 20'd703;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE  = 20'd528;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 20'd175;
  localparam logic [DUR_W-1:0] RST_TOLERANCE  = 20'd100;

  // frame byte masks
  localparam logic [FRAME_BITS-1:0] MASK_ADDR     = 32'h0000_00FF;
  localparam logic [FRAME_BITS-1:0] MASK_ADDR_INV = 32'h0000_FF00;
  localparam logic [FRAME_BITS-1:0] MASK_CMD      = 32'h00FF_0000;
  localparam logic [FRAME_BITS-1:0] MASK_CMD_INV  = 32'hFF00_0000;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [DUR_W-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic              key_held;
    logic [BYTE_W-1:0] key_address;
    logic [BYTE_W-1:0] key_command;
    logic              frame_done;
    logic              frame_error;
  } out_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] header_mark_len;
    logic [DUR_W-1:0] header_data_space;
    logic [DUR_W-1:0] header_repeat_space;
    logic [DUR_W-1:0] one_space_len;
    logic [DUR_W-1:0] zero_space_len;
    logic [DUR_W-1:0] tolerance;
  } cfg_t;

endpackage

>>> rtl/irfd_window.sv
module irfd_window (
  input  logic [irfd_pkg::DUR_W-1:0] value,
  input  logic [irfd_pkg::DUR_W-1:0] nominal,
  input  logic [irfd_pkg::DUR_W-1:0] tolerance,
  output logic                       hit
);

  logic [irfd_pkg::DUR_W-1:0] lo;
  logic [irfd_pkg::DUR_W:0]   hi;

  // lower bound saturates at zero, upper bound keeps its carry
  always_comb begin
    lo  = (nominal >= tolerance) ? (nominal - tolerance) : '0;
    hi  = {1'b0, nominal} + {1'b0, tolerance};
    hit = (value >= lo) && ({1'b0, value} <= hi);
  end

endmodule

>>> rtl/irfd_core.sv
module irfd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  irfd_pkg::in_item_t  item,
  input  irfd_pkg::cfg_t      cfg,
  output irfd_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_DATA = 3'b010,
    PH_END  = 3'b100
  } phase_t;

  phase_t                              phase, phase_next;
  logic                                first_edge_pending, first_edge_pending_next;
  logic [irfd_pkg::DUR_W-1:0]          mark_length, mark_length_next;
  logic [irfd_pkg::CNT_W-1:0]          bit_count, bit_count_next;
  logic [irfd_pkg::FRAME_BITS-1:0]     shift_word, shift_word_next;
  logic                                held_flag, held_flag_next;
  logic [irfd_pkg::BYTE_W-1:0]         held_address, held_address_next;
  logic [irfd_pkg::BYTE_W-1:0]         held_command, held_command_next;

  logic                                mark_hdr, sp_data, sp_repeat, sp_one, sp_zero;
  logic                                done, err;
  logic [irfd_pkg::CNT_W-1:0]          cnt_inc;
  logic [irfd_pkg::FRAME_BITS-1:0]     word_upd;
  logic [irfd_pkg::BYTE_W-1:0]         addr, addr_inv, cmd, cmd_inv;

  // tolerance windows
  irfd_window u_win_mark (
    .value(mark_length), .nominal(cfg.header_mark_len), .tolerance(cfg.tolerance),
    .hit(mark_hdr)
  );
  irfd_window u_win_data (
    .value(item.duration), .nominal(cfg.header_data_space), .tolerance(cfg.tolerance),
    .hit(sp_data)
  );
  irfd_window u_win_repeat (
    .value(item.duration), .nominal(cfg.header_repeat_space), .tolerance(cfg.tolerance),
    .hit(sp_repeat)
  );
  irfd_window u_win_one (
    .value(item.duration), .nominal(cfg.one_space_len), .tolerance(cfg.tolerance),
    .hit(sp_one)
  );
  irfd_window u_win_zero (
    .value(item.duration), .nominal(cfg.zero_space_len), .tolerance(cfg.tolerance),
    .hit(sp_zero)
  );

  // data bit shift and frame bytes
  always_comb begin
    cnt_inc  = bit_count + irfd_pkg::CNT_W'(1);
    word_upd = sp_one ? (shift_word | (irfd_pkg::FRAME_BITS'(1) << bit_count[4:0]))
                      : shift_word;
    addr     = irfd_pkg::BYTE_W'(word_upd & irfd_pkg::MASK_ADDR);
    addr_inv = ~irfd_pkg::BYTE_W'((word_upd & irfd_pkg::MASK_ADDR_INV) >> 8);
    cmd      = irfd_pkg::BYTE_W'((word_upd & irfd_pkg::MASK_CMD) >> 16);
    cmd_inv  = ~irfd_pkg::BYTE_W'((word_upd & irfd_pkg::MASK_CMD_INV) >> 24);
  end

  // next state for one transaction
  always_comb begin
    phase_next              = phase;
    first_edge_pending_next = first_edge_pending;
    mark_length_next        = mark_length;
    bit_count_next          = bit_count;
    shift_word_next         = shift_word;
    held_flag_next          = held_flag;
    held_address_next       = held_address;
    held_command_next       = held_command;
    done                    = 1'b0;
    err                     = 1'b0;
    unique case (item.req_type)
      irfd_pkg::REQ_RISE: begin
        mark_length_next = item.duration;
      end
      irfd_pkg::REQ_FALL: begin
        if (first_edge_pending) begin
          first_edge_pending_next = 1'b0;
        end else begin
          unique case (phase)
            PH_WAIT: begin
              if (mark_hdr) begin
                if (sp_data) begin
                  held_flag_next = 1'b0;
                  phase_next     = PH_DATA;
                end
                if (sp_repeat) begin
                  phase_next = PH_END;
                end
                bit_count_next  = '0;
                shift_word_next = '0;
              end
            end
            PH_DATA: begin
              phase_next      = (sp_one || sp_zero) ? PH_DATA : PH_WAIT;
              shift_word_next = word_upd;
              bit_count_next  = cnt_inc;
              if (cnt_inc == irfd_pkg::CNT_W'(irfd_pkg::FRAME_BITS)) begin
                if ((addr != addr_inv) || (cmd != cmd_inv)) begin
                  held_flag_next = 1'b0;
                  phase_next     = PH_WAIT;
                  err            = 1'b1;
                end else begin
                  held_address_next = addr;
                  held_command_next = cmd;
                  held_flag_next    = 1'b1;
                  phase_next        = PH_END;
                  done              = 1'b1;
                end
              end
            end
            default: begin
              phase_next = PH_WAIT;
            end
          endcase
        end
      end
      irfd_pkg::REQ_TIMEOUT: begin
        held_flag_next = 1'b0;
        phase_next     = PH_WAIT;
      end
      default: begin
      end
    endcase
  end

  // result of this transaction
  always_comb begin
    result.key_held    = held_flag_next;
    result.key_address = held_address_next;
    result.key_command = held_command_next;
    result.frame_done  = done;
    result.frame_error = err;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_WAIT;
      first_edge_pending <= 1'b1;
      mark_length        <= '0;
      bit_count          <= '0;
      shift_word         <= '0;
      held_flag          <= 1'b0;
      held_address       <= '0;
      held_command       <= '0;
    end else if (step) begin
      phase              <= phase_next;
      first_edge_pending <= first_edge_pending_next;
      mark_length        <= mark_length_next;
      bit_count          <= bit_count_next;
      shift_word         <= shift_word_next;
      held_flag          <= held_flag_next;
      held_address       <= held_address_next;
      held_command       <= held_command_next;
    end
  end

endmodule

>>> rtl/ir_remote_frame_decoder.sv
// NEC-style infrared frame decoder fed by edge events (rising edge, falling
// edge, timeout, each with its tick count). One result per transaction. The
// block takes one transaction every clock cycle while the result is not
// stalled; each transaction passes from the input register through the
// decode logic into the result register. The decode of a transaction (window
// compares, bit shift, inverse check) is combinational logic between the two
// registers. A stalled result holds the input register, so at most two
// transactions are in flight. The user must write the timing registers through
// cfg_wr_en/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this. Indexes beyond the register list are ignored.
module ir_remote_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  irfd_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output irfd_pkg::out_item_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [irfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irfd_pkg::DUR_W-1:0]         cfg_data
);

  irfd_pkg::cfg_t      cfg;
  irfd_pkg::in_item_t  item;
  irfd_pkg::out_item_t result;
  logic                item_valid;
  logic                advance;
  logic                step;

  // pipeline moves when the result register is free or being drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;
  assign step     = item_valid && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_mark_len     <= irfd_pkg::RST_HDR_MARK;
      cfg.header_data_space   <= irfd_pkg::RST_HDR_DATA;
      cfg.header_repeat_space <= irfd_pkg::RST_HDR_REPEAT;
      cfg.one_space_len       <= irfd_pkg::RST_ONE_SPACE;
      cfg.zero_space_len      <= irfd_pkg::RST_ZERO_SPACE;
      cfg.tolerance           <= irfd_pkg::RST_TOLERANCE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        irfd_pkg::CFG_HDR_MARK:   cfg.header_mark_len     <= cfg_data;
        irfd_pkg::CFG_HDR_DATA:   cfg.header_data_space   <= cfg_data;
        irfd_pkg::CFG_HDR_REPEAT: cfg.header_repeat_space <= cfg_data;
        irfd_pkg::CFG_ONE_SPACE:  cfg.one_space_len       <= cfg_data;
        irfd_pkg::CFG_ZERO_SPACE: cfg.zero_space_len      <= cfg_data;
        irfd_pkg::CFG_TOLERANCE:  cfg.tolerance           <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  irfd_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (item),
    .cfg   (cfg),
    .result(result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/irfd_checker.sv
module irfd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input irfd_pkg::out_item_t            out_data
);

  // a frame is either good or bad, never both
  a_done_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.frame_done && out_data.frame_error))
    else $error("frame_done and frame_error together");

  // a good frame leaves the key held
  a_done_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_done) |-> out_data.key_held)
    else $error("good frame without key held");

  // a failed check releases the key
  a_err_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_error) |-> !out_data.key_held)
    else $error("failed frame with key still held");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // input stalls only behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |-> (out_valid && out_stall))
    else $error("input stalled with result side free");

endmodule

bind ir_remote_frame_decoder irfd_checker u_irfd_checker (.*);
